>>> hdl/spq_pkg.sv
// shared types and constants for the sorted array priority queue
package spq_pkg;

	localparam int unsigned SPQ_CAPACITY = 16;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W    = 5;

	// operation select carried in tuser
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_PLACE,
		ST_REM,
		ST_FIN
	} spq_state_t;

endpackage

>>> hdl/sorted_array_priority_queue.sv
// sorted array min-priority queue with a single entry memory and a shift sequencer
//
// The queue keeps up to CAPACITY signed 32-bit values in ascending order in one
// synchronous memory (one write port, one read port, registered read).
// tuser[0] on the slave side selects the operation (0 insert, 1 remove smallest)
// and tdata carries the value. An insert goes behind every stored value less than
// or equal to it, so equal values leave in arrival order. Every transaction gives
// exactly one result: removed value and occupancy in tdata, status in tuser.
// One item is worked at a time. An insert reads the stored entries from the top
// down and moves each one greater than the new value up one slot, one per cycle,
// then writes the new value; a first entry in an empty queue goes straight in.
// A remove moves every remaining entry down one slot through the memory, one per
// cycle. Rejected operations (insert when full, remove when empty) move nothing.
// This pace is set by the single read and single write port of the memory.
// A finished result sits in an output register, so the next transaction is taken
// while it waits; the sequencer only holds when a second result is ready before
// the first one has been taken.
module sorted_array_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY = SPQ_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [0:0]  s_tuser,   // [0] func
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] occupancy, zero fill
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);  // count width
	localparam int unsigned AW = $clog2(CAPACITY);      // memory address width

	// entry memory
	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rdata;
	logic [AW-1:0]      raddr;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] wdata;

	spq_state_t state_q, state_d;

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [STATUS_W-1:0]       status_q;
	logic [VALUE_W-1:0]        removed_q;

	// output register
	logic                m_valid_q;
	logic [VALUE_W-1:0]  m_value_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [OCC_W-1:0]    m_occ_q;

	logic [CW-1:0] count_m1;
	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_m2;
	logic [CW-1:0] idx_p1;
	logic          accept;
	logic          full;
	logic          empty;
	logic          shift_up;     // stored entry is greater than the new value
	logic          rem_more;     // more entries left to move down
	logic          out_free;

	assign count_m1 = count_q - CW'(1);
	assign idx_m1   = idx_q - CW'(1);
	assign idx_m2   = idx_q - CW'(2);
	assign idx_p1   = idx_q + CW'(1);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign shift_up = (value_q < $signed(rdata));
	assign rem_more = (idx_p1 < count_q);
	assign out_free = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, m_occ_q, m_value_q};
	assign m_tuser  = m_status_q;

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser[0] == FUNC_INSERT) begin
						state_d = (full || empty) ? ST_FIN : ST_INS;
					end else begin
						state_d = empty ? ST_FIN : ST_REM;
					end
				end
			end
			ST_INS: begin
				if (shift_up) begin
					state_d = (idx_q == CW'(1)) ? ST_PLACE : ST_INS;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_PLACE: state_d = ST_FIN;
			ST_REM:   state_d = rem_more ? ST_REM : ST_FIN;
			ST_FIN:   state_d = out_free ? ST_IDLE : ST_FIN;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory access control
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = value_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tuser[0] == FUNC_INSERT) begin
					raddr = count_m1[AW-1:0];
					// first entry of an empty queue goes straight in
					if (accept && empty) begin
						we    = 1'b1;
						waddr = '0;
						wdata = s_tdata;
					end
				end
			end
			ST_INS: begin
				we    = 1'b1;
				waddr = idx_q[AW-1:0];
				if (shift_up) begin
					wdata = rdata;
					raddr = idx_m2[AW-1:0];
				end
			end
			ST_PLACE: begin
				we    = 1'b1;
				waddr = '0;
			end
			ST_REM: begin
				raddr = idx_p1[AW-1:0];
				if (idx_q != '0) begin
					we    = 1'b1;
					waddr = idx_m1[AW-1:0];
					wdata = rdata;
				end
			end
			ST_FIN:  ;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept && s_tuser[0] == FUNC_INSERT && empty) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_INS && !shift_up) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_PLACE) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_REM && !rem_more) begin
				count_q <= count_m1;
			end
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					value_q   <= s_tdata;
					removed_q <= '0;
					if (s_tuser[0] == FUNC_INSERT) begin
						idx_q    <= count_q;
						status_q <= full ? STATUS_FULL : STATUS_DONE;
					end else begin
						idx_q    <= '0;
						status_q <= empty ? STATUS_EMPTY : STATUS_DONE;
					end
				end
			end
			ST_INS: begin
				if (shift_up) begin
					idx_q <= idx_m1;
				end
			end
			ST_REM: begin
				// slot 0 holds the smallest value
				if (idx_q == '0) begin
					removed_q <= rdata;
				end
				idx_q <= idx_p1;
			end
			ST_FIN: begin
				if (out_free) begin
					m_value_q  <= removed_q;
					m_status_q <= status_q;
					m_occ_q    <= OCC_W'(count_q);
				end
			end
			ST_PLACE: ;
			default:  ;
		endcase
	end

endmodule

>>> bench/tb_sorted_array_priority_queue.sv
// self-checking testbench for the sorted array min-priority queue
module tb_sorted_array_priority_queue;
	import spq_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1750;
	// longest correct quiet spell is an insert, a sender gap and a receiver stall together
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned REPORT_MAX   = 10;
	localparam int unsigned DIRECTED_N   = 24;

	// one result transaction, field by field
	typedef struct packed {
		logic [VALUE_W-1:0]  removed;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
	} pq_result_t;

	// one row of the directed stimulus table; typed rows carry their own expectation
	typedef struct packed {
		logic               func;
		logic [VALUE_W-1:0] value;
		logic               typed;
		pq_result_t         want;
	} stim_row_t;

	localparam pq_result_t NO_WANT = '0;

	localparam stim_row_t DIRECTED [DIRECTED_N] = '{
		// remove from an empty queue right after reset
		'{FUNC_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, STATUS_EMPTY, 5'd0}},
		// largest and smallest signed values, smallest must leave first
		'{FUNC_INSERT, 32'h7fff_ffff, 1'b1, '{32'h0, STATUS_DONE, 5'd1}},
		'{FUNC_INSERT, 32'h8000_0000, 1'b1, '{32'h0, STATUS_DONE, 5'd2}},
		'{FUNC_REMOVE, 32'hffff_ffff, 1'b1, '{32'h8000_0000, STATUS_DONE, 5'd1}},
		'{FUNC_REMOVE, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, STATUS_DONE, 5'd0}},
		'{FUNC_REMOVE, 32'h1234_5678, 1'b1, '{32'h0, STATUS_EMPTY, 5'd0}},
		// fill to capacity with duplicates and mixed signs
		'{FUNC_INSERT, 32'd5,         1'b0, NO_WANT},
		'{FUNC_INSERT, -32'sd3,       1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd5,         1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd0,         1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd5,         1'b0, NO_WANT},
		'{FUNC_INSERT, 32'hffff_ffff, 1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd100,       1'b0, NO_WANT},
		'{FUNC_INSERT, -32'sd100,     1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd0,         1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd7,         1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd7,         1'b0, NO_WANT},
		'{FUNC_INSERT, 32'h8000_0000, 1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd1,         1'b0, NO_WANT},
		'{FUNC_INSERT, 32'h7fff_ffff, 1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd3,         1'b0, NO_WANT},
		'{FUNC_INSERT, 32'd4,         1'b0, NO_WANT},
		// insert into a full queue is rejected, count stays at capacity
		'{FUNC_INSERT, 32'hdead_beef, 1'b1, '{32'h0, STATUS_FULL, 5'd16}},
		'{FUNC_REMOVE, 32'h0000_0000, 1'b0, NO_WANT}
	};

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b1;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [31:0]        s_tdata  = '0;
	logic [0:0]         s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [39:0]        m_tdata;
	logic [1:0]         m_tuser;

	// shadow copy of the stored list, ascending, slot 0 at the front
	logic signed [VALUE_W-1:0] shadow_list [$];
	// results still owed by the block, oldest first
	pq_result_t                owed_results [$];

	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	// when clear, both sides run without gaps or stalls
	bit          idling_on    = 1'b1;

	sorted_array_priority_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// apply one operation to the shadow list and return what the block must answer
	function automatic pq_result_t queue_apply(logic func, logic signed [VALUE_W-1:0] val);
		pq_result_t r;
		int         pos;
		r = '{removed: '0, status: STATUS_DONE, occupancy: '0};
		if (func == FUNC_INSERT) begin
			if (shadow_list.size() >= SPQ_CAPACITY) begin
				r.status = STATUS_FULL;
			end else begin
				// walk down past every entry strictly greater, so ties keep arrival order
				pos = shadow_list.size();
				while (pos > 0 && val < shadow_list[pos-1])
					pos--;
				shadow_list.insert(pos, val);
			end
		end else begin
			if (shadow_list.size() == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.removed = shadow_list.pop_front();
			end
		end
		r.occupancy = OCC_W'(shadow_list.size());
		return r;
	endfunction

	// value mix: small range for ties, the signed extremes, zero and minus one, and full random words
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return VALUE_W'($signed($urandom_range(0, 12)) - 6);
		if (sel == 4) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	// drive one request transaction and record what it must produce
	task automatic send_request(logic func, logic [VALUE_W-1:0] val, logic typed,
			pq_result_t want);
		int unsigned gap;
		pq_result_t  predicted;
		gap = idling_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= func;
		do @(posedge clk); while (!s_tready);
		// the shadow list always moves; typed rows take the table's expectation
		predicted = queue_apply(func, val);
		owed_results.push_back(typed ? want : predicted);
	endtask

	// stimulus: directed table first, then random bursts
	initial begin
		int unsigned sent;
		int unsigned burst_len;
		int unsigned insert_pct;
		logic        func;
		// clean falling edge so the asynchronous reset is seen
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idling_on = 1'b0;
		for (int i = 0; i < DIRECTED_N; i++)
			send_request(DIRECTED[i].func, DIRECTED[i].value, DIRECTED[i].typed,
				DIRECTED[i].want);

		// bursts lean toward insert or remove, or mix them evenly, so the queue swings between empty and full
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: insert_pct = 15;
				1: insert_pct = 50;
				default: insert_pct = 85;
			endcase
			idling_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
				func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
				send_request(func, pick_value(), 1'b0, NO_WANT);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		// drain, then give the block time to show any stray result
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stalls, compare each transaction with the oldest expectation
	initial begin
		int unsigned stall;
		pq_result_t  got;
		pq_result_t  exp_r;
		@(posedge arst_n);
		forever begin
			stall = idling_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = '{removed: m_tdata[31:0], status: m_tuser, occupancy: m_tdata[36:32]};
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: removed=%h status=%0d occupancy=%0d",
						got.removed, got.status, got.occupancy);
			end else begin
				exp_r = owed_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("result mismatch: expected removed=%h status=%0d occupancy=%0d",
							exp_r.removed, exp_r.status, exp_r.occupancy);
						$display("                 got      removed=%h status=%0d occupancy=%0d",
							got.removed, got.status, got.occupancy);
					end
				end
			end
		end
	end

	// watchdog: too long without any transaction on either side ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
